// ===== sv/b2l_pkg.sv =====
// b2l_pkg: shared widths, fixed-point constants, arctangent table and pipeline
// data types for the body-to-local point transform.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package b2l_pkg;

    // field widths
    localparam int QUAT_W    = 16;
    localparam int POS_W     = 32;
    localparam int LABEL_W   = 4;
    localparam int HEAD_W    = 19;

    // internal datapath widths
    localparam int VEC_W     = 37;   // vectoring x/y, holds the gain-grown magnitude
    localparam int ANG_W     = 35;   // Q.30 angles with room for table sums
    localparam int ROT_W     = 50;   // rotation x/y, Q32.16 plus gain growth
    localparam int FIN_W     = 52;   // final add with the vehicle position
    localparam int PROD_W    = 2 * QUAT_W;
    localparam int TABLE_LEN = 32;
    localparam int GUARD     = 16;

    typedef logic signed [VEC_W-1:0]  t_vec_word;
    typedef logic signed [ANG_W-1:0]  t_ang;
    typedef logic signed [ROT_W-1:0]  t_rot_word;
    typedef logic signed [FIN_W-1:0]  t_fin;
    typedef logic signed [POS_W-1:0]  t_pos;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [HEAD_W-1:0] t_head;
    typedef logic [LABEL_W-1:0]       t_label;

    // angle and scaling constants, Q.30
    localparam t_ang PI_Q30      = 35'sd3373259426;
    localparam t_ang HALF_PI_Q30 = 35'sd1686629713;
    localparam t_pos INV_GAIN_Q30 = 32'sh26DD3B6A;

    localparam t_vec_word ONE_Q28      = 37'sd268435456;
    localparam t_ang      HEAD_ROUND   = 35'sd8192;
    localparam int        HEAD_SHIFT   = 14;
    localparam t_ang      HEADING_MAX  = 35'sd205887;
    localparam int        SCALE_SHIFT  = 30 - GUARD;
    localparam t_fin      FIN_ROUND    = 52'sd32768;
    localparam t_fin      FIN_POS_MAX  = 52'sd2147483647;
    localparam t_fin      FIN_POS_MIN  = -52'sd2147483648;

    // truncated arctangent table, atan(2^-i) in Q.30
    localparam logic [29:0] ATAN_Q30 [TABLE_LEN] = '{
        30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6,
        30'h03FEAB76, 30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55,
        30'h003FFFEA, 30'h001FFFFD, 30'h000FFFFF, 30'h0007FFFF,
        30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF, 30'h00007FFF,
        30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
        30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F,
        30'h0000003F, 30'h0000001F, 30'h0000000F, 30'h00000008,
        30'h00000004, 30'h00000002, 30'h00000001, 30'h00000000
    };

    // vectoring cell state
    typedef struct packed {
        t_vec_word x;
        t_vec_word y;
        t_ang      z;
    } t_vec_state;

    // rotation cell state
    typedef struct packed {
        t_rot_word x;
        t_rot_word y;
        t_ang      theta;
    } t_rot_state;

    // items that ride along the vectoring chain
    typedef struct packed {
        t_rot_word px;
        t_rot_word py;
        t_pos      vx;
        t_pos      vy;
        t_label    label;
        logic      zero;
    } t_vec_side;

    // items that ride along the rotation chain
    typedef struct packed {
        t_pos   vx;
        t_pos   vy;
        t_label label;
        t_head  heading;
    } t_rot_side;

endpackage

`default_nettype wire

// ===== sv/b2l_vec_cell.sv =====
// b2l_vec_cell: one CORDIC vectoring cell of the yaw chain, registered.
// Depends on b2l_pkg for the state types and the arctangent table.
`default_nettype none

module b2l_vec_cell #(
    parameter int STAGE = 0
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_valid,
    input  wire b2l_pkg::t_vec_state i_data,
    input  wire b2l_pkg::t_vec_side  i_side,
    output logic                     o_valid,
    output b2l_pkg::t_vec_state      o_data,
    output b2l_pkg::t_vec_side       o_side
);

    localparam b2l_pkg::t_ang ATAN_STEP = b2l_pkg::t_ang'(b2l_pkg::ATAN_Q30[STAGE]);

    b2l_pkg::t_vec_word dx;
    b2l_pkg::t_vec_word dy;
    b2l_pkg::t_vec_state n_data;
    logic r_valid;
    b2l_pkg::t_vec_state r_data;
    b2l_pkg::t_vec_side  r_side;

    // drive y toward zero, accumulate the angle
    always_comb begin
        dx = i_data.y >>> STAGE;
        dy = i_data.x >>> STAGE;
        if (!i_data.y[b2l_pkg::VEC_W-1]) begin
            n_data.x = i_data.x + dx;
            n_data.y = i_data.y - dy;
            n_data.z = i_data.z + ATAN_STEP;
        end else begin
            n_data.x = i_data.x - dx;
            n_data.y = i_data.y + dy;
            n_data.z = i_data.z - ATAN_STEP;
        end
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_side <= i_side;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_side  = r_side;

endmodule

`default_nettype wire

// ===== sv/b2l_rot_cell.sv =====
// b2l_rot_cell: one CORDIC rotation cell of the point rotation chain, registered.
// Depends on b2l_pkg for the state types and the arctangent table.
`default_nettype none

module b2l_rot_cell #(
    parameter int STAGE = 0
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_valid,
    input  wire b2l_pkg::t_rot_state i_data,
    input  wire b2l_pkg::t_rot_side  i_side,
    output logic                     o_valid,
    output b2l_pkg::t_rot_state      o_data,
    output b2l_pkg::t_rot_side       o_side
);

    localparam b2l_pkg::t_ang ATAN_STEP = b2l_pkg::t_ang'(b2l_pkg::ATAN_Q30[STAGE]);

    b2l_pkg::t_rot_word dx;
    b2l_pkg::t_rot_word dy;
    b2l_pkg::t_rot_state n_data;
    logic r_valid;
    b2l_pkg::t_rot_state r_data;
    b2l_pkg::t_rot_side  r_side;

    // drive the residual angle toward zero
    always_comb begin
        dx = i_data.y >>> STAGE;
        dy = i_data.x >>> STAGE;
        if (!i_data.theta[b2l_pkg::ANG_W-1]) begin
            n_data.x     = i_data.x - dx;
            n_data.y     = i_data.y + dy;
            n_data.theta = i_data.theta - ATAN_STEP;
        end else begin
            n_data.x     = i_data.x + dx;
            n_data.y     = i_data.y - dy;
            n_data.theta = i_data.theta + ATAN_STEP;
        end
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_side <= i_side;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_side  = r_side;

endmodule

`default_nettype wire

// ===== sv/body_to_local_point_transform.sv =====
// body_to_local_point_transform: top level, front-end products, a vectoring chain
// for the yaw, a rotation chain for the point, and the final add and saturation.
// Depends on b2l_pkg, b2l_vec_cell and b2l_rot_cell.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------------
//  input    | start / busy       | i_quat_w/x/y/z, i_vehicle_x/y, i_rel_x/y, i_label_code
//  result   | o_valid (strobe)   | o_local_x, o_local_y, o_heading, o_label_out
//
// One item is taken per clock; busy stays low, so a transfer happens on every
// cycle with start high.
// From the input transfer to the result strobe an item passes two front-end
// stages, the vectoring cells, two stages for yaw and pre-rotation, the rotation
// cells and the output register.
// Synchronous active-low reset clears only the valid bits along the pipeline.
// The result strobe lasts one cycle; the receiver cannot hold it off.
`default_nettype none

module body_to_local_point_transform #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [15:0] i_quat_w,
    input  wire  [15:0] i_quat_x,
    input  wire  [15:0] i_quat_y,
    input  wire  [15:0] i_quat_z,
    input  wire  [31:0] i_vehicle_x,
    input  wire  [31:0] i_vehicle_y,
    input  wire  [31:0] i_rel_x,
    input  wire  [31:0] i_rel_y,
    input  wire  [3:0]  i_label_code,
    output logic        o_valid,
    output logic [31:0] o_local_x,
    output logic [31:0] o_local_y,
    output logic [18:0] o_heading,
    output logic [3:0]  o_label_out
);

    localparam int N = (CORDIC_STAGES < b2l_pkg::TABLE_LEN) ? CORDIC_STAGES
                                                            : b2l_pkg::TABLE_LEN;

    logic accept;

    // stage a: products
    logic                r_a_valid;
    b2l_pkg::t_prod      r_p_wz, r_p_xy, r_p_yy, r_p_zz;
    b2l_pkg::t_rot_word  r_a_px, r_a_py;
    b2l_pkg::t_pos       r_a_vx, r_a_vy;
    b2l_pkg::t_label     r_a_label;
    logic signed [63:0]  scale_x, scale_y;

    // stage b: sine/cosine terms and vectoring pre-rotation
    b2l_pkg::t_vec_word  s_term, c_term;
    b2l_pkg::t_vec_state n_vec0;
    logic                r_vec0_valid;
    b2l_pkg::t_vec_state r_vec0;
    b2l_pkg::t_vec_side  r_vec0_side;

    // vectoring chain
    logic                vec_v    [0:N];
    b2l_pkg::t_vec_state vec_d    [0:N];
    b2l_pkg::t_vec_side  vec_s    [0:N];

    // stage c: yaw
    b2l_pkg::t_ang       n_yaw;
    logic                r_c_valid;
    b2l_pkg::t_ang       r_c_yaw;
    b2l_pkg::t_vec_side  r_c_side;

    // stage d: heading and rotation pre-rotation
    b2l_pkg::t_ang       head_full;
    b2l_pkg::t_head      n_heading;
    b2l_pkg::t_ang       theta0;
    b2l_pkg::t_rot_state n_rot0;
    logic                r_rot0_valid;
    b2l_pkg::t_rot_state r_rot0;
    b2l_pkg::t_rot_side  r_rot0_side;

    // rotation chain
    logic                rot_v    [0:N];
    b2l_pkg::t_rot_state rot_d    [0:N];
    b2l_pkg::t_rot_side  rot_s    [0:N];

    // stage e: output
    b2l_pkg::t_fin       sum_x, sum_y, sh_x, sh_y;
    b2l_pkg::t_pos       n_local_x, n_local_y;
    logic                r_out_valid;
    b2l_pkg::t_pos       r_local_x, r_local_y;
    b2l_pkg::t_head      r_heading;
    b2l_pkg::t_label     r_label;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // gain-compensation scaling of the relative point
    assign scale_x = $signed(i_rel_x) * b2l_pkg::INV_GAIN_Q30;
    assign scale_y = $signed(i_rel_y) * b2l_pkg::INV_GAIN_Q30;

    // stage a valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= accept;
        end
    end

    // stage a payload
    always_ff @(posedge i_clk) begin
        r_p_wz    <= $signed(i_quat_w) * $signed(i_quat_z);
        r_p_xy    <= $signed(i_quat_x) * $signed(i_quat_y);
        r_p_yy    <= $signed(i_quat_y) * $signed(i_quat_y);
        r_p_zz    <= $signed(i_quat_z) * $signed(i_quat_z);
        r_a_px    <= b2l_pkg::t_rot_word'(scale_x >>> b2l_pkg::SCALE_SHIFT);
        r_a_py    <= b2l_pkg::t_rot_word'(scale_y >>> b2l_pkg::SCALE_SHIFT);
        r_a_vx    <= i_vehicle_x;
        r_a_vy    <= i_vehicle_y;
        r_a_label <= i_label_code;
    end

    // sine and cosine terms, quarter-turn pre-rotation for a negative cosine
    always_comb begin
        s_term = (b2l_pkg::t_vec_word'(r_p_wz) + b2l_pkg::t_vec_word'(r_p_xy)) <<< 1;
        c_term = b2l_pkg::ONE_Q28
               - ((b2l_pkg::t_vec_word'(r_p_yy) + b2l_pkg::t_vec_word'(r_p_zz)) <<< 1);
        if (c_term[b2l_pkg::VEC_W-1]) begin
            if (!s_term[b2l_pkg::VEC_W-1]) begin
                n_vec0.x = s_term;
                n_vec0.y = -c_term;
                n_vec0.z = b2l_pkg::HALF_PI_Q30;
            end else begin
                n_vec0.x = -s_term;
                n_vec0.y = c_term;
                n_vec0.z = -b2l_pkg::HALF_PI_Q30;
            end
        end else begin
            n_vec0.x = c_term;
            n_vec0.y = s_term;
            n_vec0.z = '0;
        end
    end

    // stage b registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vec0_valid <= 1'b0;
        end else begin
            r_vec0_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vec0            <= n_vec0;
        r_vec0_side.px    <= r_a_px;
        r_vec0_side.py    <= r_a_py;
        r_vec0_side.vx    <= r_a_vx;
        r_vec0_side.vy    <= r_a_vy;
        r_vec0_side.label <= r_a_label;
        r_vec0_side.zero  <= (s_term == '0) && (c_term == '0);
    end

    assign vec_v[0] = r_vec0_valid;
    assign vec_d[0] = r_vec0;
    assign vec_s[0] = r_vec0_side;

    // vectoring cells
    for (genvar k = 0; k < N; k++) begin : g_vec
        b2l_vec_cell #(
            .STAGE(k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (vec_v[k]),
            .i_data  (vec_d[k]),
            .i_side  (vec_s[k]),
            .o_valid (vec_v[k+1]),
            .o_data  (vec_d[k+1]),
            .o_side  (vec_s[k+1])
        );
    end

    // yaw: zero vector gives zero, otherwise clamp to +-pi
    always_comb begin
        if (vec_s[N].zero) begin
            n_yaw = '0;
        end else if (vec_d[N].z > b2l_pkg::PI_Q30) begin
            n_yaw = b2l_pkg::PI_Q30;
        end else if (vec_d[N].z < -b2l_pkg::PI_Q30) begin
            n_yaw = -b2l_pkg::PI_Q30;
        end else begin
            n_yaw = vec_d[N].z;
        end
    end

    // stage c registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else begin
            r_c_valid <= vec_v[N];
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_yaw  <= n_yaw;
        r_c_side <= vec_s[N];
    end

    // heading rounding and clamp; half-turn pre-rotation of the point
    always_comb begin
        head_full = (r_c_yaw + b2l_pkg::HEAD_ROUND) >>> b2l_pkg::HEAD_SHIFT;
        if (head_full > b2l_pkg::HEADING_MAX) begin
            n_heading = b2l_pkg::t_head'(b2l_pkg::HEADING_MAX);
        end else if (head_full < -b2l_pkg::HEADING_MAX) begin
            n_heading = b2l_pkg::t_head'(-b2l_pkg::HEADING_MAX);
        end else begin
            n_heading = b2l_pkg::t_head'(head_full);
        end
        theta0 = r_c_yaw - b2l_pkg::HALF_PI_Q30;
        if (theta0 < -b2l_pkg::HALF_PI_Q30) begin
            n_rot0.x     = -r_c_side.px;
            n_rot0.y     = -r_c_side.py;
            n_rot0.theta = theta0 + b2l_pkg::PI_Q30;
        end else begin
            n_rot0.x     = r_c_side.px;
            n_rot0.y     = r_c_side.py;
            n_rot0.theta = theta0;
        end
    end

    // stage d registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot0_valid <= 1'b0;
        end else begin
            r_rot0_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rot0              <= n_rot0;
        r_rot0_side.vx      <= r_c_side.vx;
        r_rot0_side.vy      <= r_c_side.vy;
        r_rot0_side.label   <= r_c_side.label;
        r_rot0_side.heading <= n_heading;
    end

    assign rot_v[0] = r_rot0_valid;
    assign rot_d[0] = r_rot0;
    assign rot_s[0] = r_rot0_side;

    // rotation cells
    for (genvar k = 0; k < N; k++) begin : g_rot
        b2l_rot_cell #(
            .STAGE(k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (rot_v[k]),
            .i_data  (rot_d[k]),
            .i_side  (rot_s[k]),
            .o_valid (rot_v[k+1]),
            .o_data  (rot_d[k+1]),
            .o_side  (rot_s[k+1])
        );
    end

    // add the vehicle position, round to nearest, saturate
    always_comb begin
        sum_x = b2l_pkg::t_fin'(rot_d[N].x)
              + (b2l_pkg::t_fin'(rot_s[N].vx) <<< b2l_pkg::GUARD) + b2l_pkg::FIN_ROUND;
        sum_y = b2l_pkg::t_fin'(rot_d[N].y)
              + (b2l_pkg::t_fin'(rot_s[N].vy) <<< b2l_pkg::GUARD) + b2l_pkg::FIN_ROUND;
        sh_x  = sum_x >>> b2l_pkg::GUARD;
        sh_y  = sum_y >>> b2l_pkg::GUARD;
        if (sh_x > b2l_pkg::FIN_POS_MAX) begin
            n_local_x = b2l_pkg::t_pos'(b2l_pkg::FIN_POS_MAX);
        end else if (sh_x < b2l_pkg::FIN_POS_MIN) begin
            n_local_x = b2l_pkg::t_pos'(b2l_pkg::FIN_POS_MIN);
        end else begin
            n_local_x = b2l_pkg::t_pos'(sh_x);
        end
        if (sh_y > b2l_pkg::FIN_POS_MAX) begin
            n_local_y = b2l_pkg::t_pos'(b2l_pkg::FIN_POS_MAX);
        end else if (sh_y < b2l_pkg::FIN_POS_MIN) begin
            n_local_y = b2l_pkg::t_pos'(b2l_pkg::FIN_POS_MIN);
        end else begin
            n_local_y = b2l_pkg::t_pos'(sh_y);
        end
    end

    // output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= rot_v[N];
        end
    end

    always_ff @(posedge i_clk) begin
        r_local_x <= n_local_x;
        r_local_y <= n_local_y;
        r_heading <= rot_s[N].heading;
        r_label   <= rot_s[N].label;
    end

    assign o_valid     = r_out_valid;
    assign o_local_x   = r_local_x;
    assign o_local_y   = r_local_y;
    assign o_heading   = r_heading;
    assign o_label_out = r_label;

    // heading on a transfer stays inside the clamp range
    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($signed(o_heading) <= 205887 && $signed(o_heading) >= -205887))
        else $error("heading outside clamp range");

    // a zero sine/cosine pair yields a zero yaw
    a_zero_yaw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (vec_v[N] && vec_s[N].zero) |=> (r_c_yaw == '0))
        else $error("zero vector did not give zero yaw");

    // after the half-turn pre-rotation the residual angle is at least -pi/2
    a_rot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rot0_valid |-> (r_rot0.theta >= -b2l_pkg::HALF_PI_Q30))
        else $error("rotation angle below -pi/2 after pre-rotation");

endmodule

`default_nettype wire

// ===== sim/tb_body_to_local_point_transform.sv =====
// tb_body_to_local_point_transform: self-checking bench for the body-to-local point transform,
// with its own fixed-point CORDIC predictor, a start/busy driver and a strobe monitor.
// Depends on b2l_pkg and body_to_local_point_transform.

module tb_body_to_local_point_transform;

    localparam int     STAGES       = 16;
    localparam int     USED_STAGES  = (STAGES < 32) ? STAGES : 32;
    localparam int     LATENCY      = 2 * STAGES + 5;
    localparam int     N_RANDOM     = 1100;
    localparam int     LIMIT_CYCLES = 200000;
    localparam longint PI_Q30       = 64'sd3373259426;
    localparam longint HALF_PI_Q30  = 64'sd1686629713;
    localparam longint INV_GAIN     = 64'sh26DD3B6A;
    localparam longint HEAD_LIMIT   = 64'sd205887;
    localparam longint POS_MAX      = 64'sd2147483647;
    localparam longint POS_MIN      = -64'sd2147483648;

    // arctangent of 2^-i in Q.30, truncated
    localparam longint ATAN_Q30 [32] = '{
        'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
        'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
        'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
        'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
        'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002,
        'h00000001, 'h00000000
    };

    typedef logic signed [b2l_pkg::QUAT_W-1:0] t_quat;

    typedef struct packed {
        t_quat            quat_w;
        t_quat            quat_x;
        t_quat            quat_y;
        t_quat            quat_z;
        b2l_pkg::t_pos    vehicle_x;
        b2l_pkg::t_pos    vehicle_y;
        b2l_pkg::t_pos    rel_x;
        b2l_pkg::t_pos    rel_y;
        b2l_pkg::t_label  label_code;
    } t_detection;

    typedef struct packed {
        b2l_pkg::t_pos    local_x;
        b2l_pkg::t_pos    local_y;
        b2l_pkg::t_head   heading;
        b2l_pkg::t_label  label_out;
    } t_local_point;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic o_valid;
    logic [31:0] o_local_x;
    logic [31:0] o_local_y;
    logic [18:0] o_heading;
    logic [3:0]  o_label_out;

    t_detection   cur_det = '0;
    t_detection   pending_dets [$];
    t_local_point exp_points [$];
    t_local_point front_point;
    logic         took = 1'b0;
    int           dets_sent = 0;
    int           points_checked = 0;
    int           sat_coords = 0;
    int           neg_headings = 0;
    int           err_count = 0;
    int           cycle_count = 0;

    body_to_local_point_transform #(
        .CORDIC_STAGES(STAGES)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_quat_w     (cur_det.quat_w),
        .i_quat_x     (cur_det.quat_x),
        .i_quat_y     (cur_det.quat_y),
        .i_quat_z     (cur_det.quat_z),
        .i_vehicle_x  (cur_det.vehicle_x),
        .i_vehicle_y  (cur_det.vehicle_y),
        .i_rel_x      (cur_det.rel_x),
        .i_rel_y      (cur_det.rel_y),
        .i_label_code (cur_det.label_code),
        .o_valid      (o_valid),
        .o_local_x    (o_local_x),
        .o_local_y    (o_local_y),
        .o_heading    (o_heading),
        .o_label_out  (o_label_out)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // yaw of (c, s) by vectoring, Q.30, with quadrant pre-rotation and final clamp
    function automatic longint yaw_from_terms(longint c, longint s);
        longint x, y, z, dx, dy;
        z = 0;
        if (c == 0 && s == 0)
            return 0;
        if (c < 0) begin
            if (s >= 0) begin
                x = s; y = -c; z = HALF_PI_Q30;
            end else begin
                x = -s; y = c; z = -HALF_PI_Q30;
            end
        end else begin
            x = c; y = s;
        end
        for (int i = 0; i < USED_STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx; y = y - dy; z = z + ATAN_Q30[i];
            end else begin
                x = x - dx; y = y + dy; z = z - ATAN_Q30[i];
            end
        end
        return clip(z, -PI_Q30, PI_Q30);
    endfunction

    // rotation mode, angles below -pi/2 first take an exact half turn
    function automatic void rotate_by_angle(inout longint x, inout longint y, input longint ang);
        longint dx, dy;
        if (ang < -HALF_PI_Q30) begin
            x = -x; y = -y; ang = ang + PI_Q30;
        end
        for (int i = 0; i < USED_STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (ang >= 0) begin
                x = x - dx; y = y + dy; ang = ang - ATAN_Q30[i];
            end else begin
                x = x + dx; y = y - dy; ang = ang + ATAN_Q30[i];
            end
        end
    endfunction

    // add vehicle position, round off the guard bits, saturate
    function automatic longint place_coord(longint rot, longint base);
        longint sum;
        sum = rot + (base <<< 16);
        return clip((sum + 64'sd32768) >>> 16, POS_MIN, POS_MAX);
    endfunction

    function automatic t_local_point calc_local_point(t_detection d);
        t_local_point r;
        longint qw, qx, qy, qz, s, c, yaw, hd, px, py;
        qw = longint'(d.quat_w);
        qx = longint'(d.quat_x);
        qy = longint'(d.quat_y);
        qz = longint'(d.quat_z);
        s = 2 * (qw * qz + qx * qy);
        c = (64'sd1 <<< 28) - 2 * (qy * qy + qz * qz);
        yaw = yaw_from_terms(c, s);
        hd = clip((yaw + 64'sd8192) >>> 14, -HEAD_LIMIT, HEAD_LIMIT);
        px = (longint'(d.rel_x) * INV_GAIN) >>> 14;
        py = (longint'(d.rel_y) * INV_GAIN) >>> 14;
        rotate_by_angle(px, py, yaw - HALF_PI_Q30);
        r.local_x = 32'(place_coord(px, longint'(d.vehicle_x)));
        r.local_y = 32'(place_coord(py, longint'(d.vehicle_y)));
        r.heading = hd[18:0];
        r.label_out = d.label_code;
        return r;
    endfunction

    function automatic void add_det(t_quat w, t_quat x, t_quat y, t_quat z,
                                    b2l_pkg::t_pos vx, b2l_pkg::t_pos vy,
                                    b2l_pkg::t_pos rx, b2l_pkg::t_pos ry,
                                    b2l_pkg::t_label lab);
        t_detection d;
        d = '{w, x, y, z, vx, vy, rx, ry, lab};
        pending_dets.push_back(d);
    endfunction

    // mostly positions within a few hundred meters, sometimes anything
    function automatic b2l_pkg::t_pos rand_pos();
        if ($urandom_range(0, 99) < 75)
            return int'($urandom_range(0, 33554432)) - 16777216;
        return $urandom;
    endfunction

    // idle on about 15 percent of the cycles, except for a long busy stretch
    function automatic logic hold_off();
        if (dets_sent >= 300 && dets_sent < 600)
            return 1'b0;
        return $urandom_range(0, 99) < 15;
    endfunction

    // driver: present the next detection once the current one is transferred
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!start || took) begin
                if (pending_dets.size() > 0 && !hold_off()) begin
                    cur_det <= pending_dets.pop_front();
                    start <= 1'b1;
                    dets_sent <= dets_sent + 1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // input transfer: record the expected point
    always @(posedge i_clk) begin
        took <= i_rst_n && start && !busy;
        if (i_rst_n && start && !busy)
            exp_points.push_back(calc_local_point(cur_det));
    end

    // monitor: compare each strobed result with the oldest expectation
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
        if (i_rst_n && o_valid === 1'b1) begin
            if (exp_points.size() == 0) begin
                $error("unexpected result: local_x %0d local_y %0d", $signed(o_local_x),
                       $signed(o_local_y));
                err_count++;
            end else begin
                front_point = exp_points.pop_front();
                points_checked++;
                if (front_point.local_x == 32'sh7FFFFFFF || front_point.local_x == 32'sh80000000 ||
                    front_point.local_y == 32'sh7FFFFFFF || front_point.local_y == 32'sh80000000)
                    sat_coords++;
                if (front_point.heading < 0)
                    neg_headings++;
                if (o_local_x !== front_point.local_x) begin
                    $error("local_x mismatch: expected %0d, got %0d", front_point.local_x,
                           $signed(o_local_x));
                    err_count++;
                end
                if (o_local_y !== front_point.local_y) begin
                    $error("local_y mismatch: expected %0d, got %0d", front_point.local_y,
                           $signed(o_local_y));
                    err_count++;
                end
                if (o_heading !== front_point.heading) begin
                    $error("heading mismatch: expected %0d, got %0d", front_point.heading,
                           $signed(o_heading));
                    err_count++;
                end
                if (o_label_out !== front_point.label_out) begin
                    $error("label_out mismatch: expected %0d, got %0d", front_point.label_out,
                           o_label_out);
                    err_count++;
                end
            end
        end
    end

    // stimulus and end of run
    initial begin
        int sel;
        real hh;
        t_quat qw, qx, qy, qz;

        // directed: identity, extremes, quadrant and clamp cases, saturation
        add_det(16384, 0, 0, 0, 0, 0, 32'sh00010000, 32'sh00020000, 0);
        add_det(-32768, -32768, -32768, -32768, 32'sh80000000, 32'sh80000000,
                32'sh80000000, 32'sh80000000, 15);
        add_det(32767, 32767, 32767, 32767, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                32'sh7FFFFFFF, 32'sh7FFFFFFF, 10);
        add_det(0, 0, 8192, 8192, 32'sh00100000, -32'sh00100000, 32'sh00050000, 0, 5);
        add_det(0, 0, 0, 16384, 32'sh01000000, 32'sh02000000, 32'sh00030000,
                -32'sh00010000, 3);
        add_det(-1000, 0, 0, 16384, -32'sh01000000, 0, 32'sh00100000, 32'sh00100000, 4);
        add_det(1000, 0, 0, 16384, 0, 0, -32'sh00100000, 32'sh00080000, 6);
        add_det(11585, 0, 0, -11585, 32'sh00001234, 32'sh00005678, 32'sh00A00000, 0, 7);
        add_det(11585, 0, 0, 11585, 0, 0, 0, 32'sh00A00000, 8);
        add_det(16000, 0, 0, -3000, 32'sh00640000, 32'sh00C80000, 32'sh00010000,
                32'sh00010000, 9);
        add_det(3000, 0, 0, -16000, 0, 0, 32'sh00400000, -32'sh00400000, 1);
        add_det(16384, 0, 0, 0, 32'sh7FFFFFFF, 0, 0, 32'sh7FFFFFFF, 2);
        add_det(16384, 0, 0, 0, 32'sh80000000, 0, 0, 32'sh80000000, 11);
        add_det(16384, 0, 0, 0, 0, 32'sh7FFFFFFF, 32'sh80000000, 0, 12);
        add_det(16384, 0, 0, 0, 0, 32'sh80000000, 32'sh7FFFFFFF, 0, 13);
        add_det(32767, 32767, -32768, 100, 32'sh00010000, 0, 32'sh00020000, 0, 14);
        add_det(0, 0, 0, 0, 32'sh00030000, 32'sh00040000, 32'sh00050000, 32'sh00060000, 0);
        add_det(16384, 0, 0, 0, 32'sh12345678, -32'sh12345678, 0, 0, 15);
        add_det(-16384, 0, 0, 0, 0, 0, 1, -1, 3);
        add_det(0, 16384, 0, 0, 0, 0, -1, 1, 9);
        add_det(0, 0, 16384, 0, 0, 0, 32'sh00010000, 32'sh00010000, 6);
        add_det(0, 0, 0, -16384, 0, 0, 32'sh00020000, -32'sh00020000, 12);

        // random: mostly yaw-dominated near-unit quaternions, mixed with raw and extreme ones
        for (int n = 0; n < N_RANDOM; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
                hh = ($urandom_range(0, 65535) / 65535.0 - 0.5) * 6.28318530718;
                qw = 16'(int'(16384.0 * $cos(hh / 2.0)) + int'($urandom_range(0, 400)) - 200);
                qz = 16'(int'(16384.0 * $sin(hh / 2.0)) + int'($urandom_range(0, 400)) - 200);
                qx = 16'(int'($urandom_range(0, 4000)) - 2000);
                qy = 16'(int'($urandom_range(0, 4000)) - 2000);
            end else if (sel < 92) begin
                qw = 16'($urandom);
                qx = 16'($urandom);
                qy = 16'($urandom);
                qz = 16'($urandom);
            end else begin
                qw = ($urandom_range(0, 1) == 1) ? 16'sh7FFF : 16'sh8000;
                qx = ($urandom_range(0, 2) == 0) ? 16'sh0000 : 16'($urandom);
                qy = ($urandom_range(0, 1) == 1) ? 16'sh7FFF : 16'sh8000;
                qz = ($urandom_range(0, 2) == 0) ? 16'sh0000 : 16'($urandom);
            end
            add_det(qw, qx, qy, qz, rand_pos(), rand_pos(), rand_pos(), rand_pos(),
                    4'($urandom_range(0, 15)));
        end

        // reset
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // drain: all transfers done, all points back, then pipeline flush
        wait (pending_dets.size() == 0 && start == 1'b0);
        while (exp_points.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);

        $display("%0d detections transferred, %0d local points checked", dets_sent,
                 points_checked);
        $display("%0d points with a saturated coordinate, %0d with negative heading",
                 sat_coords, neg_headings);
        if (err_count == 0 && exp_points.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
